>>> rtl/sptsa_pkg.sv
// Package: shared types and constants of the sparse polynomial term store adder.
`timescale 1ns / 1ps
package sptsa_pkg;

	localparam int TERMS_PER_POLY = 32;
	localparam int COEF_W = 16;
	localparam int EXPO_W = 16;
	localparam int SUM_W = 17;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_SUM    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_TERM     = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	// per-list operation broadcast to the row of cells
	typedef enum logic [1:0] {
		LOP_HOLD = 2'd0,
		LOP_ROT  = 2'd1,
		LOP_POP  = 2'd2,
		LOP_PUSH = 2'd3
	} lop_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_WALK   = 2'd1,
		S_FINISH = 2'd2,
		S_SUM    = 2'd3
	} state_t;

endpackage

>>> rtl/sptsa_if.sv
// Interfaces: command channel and result channel of the term store adder.
`timescale 1ns / 1ps
interface sptsa_req_if;
	logic                                valid;
	logic                                ready;
	sptsa_pkg::cmd_t                     command;
	logic                                poly_select;
	logic signed [sptsa_pkg::COEF_W-1:0] term_coef;
	logic [sptsa_pkg::EXPO_W-1:0]        term_expo;

	modport source (output valid, command, poly_select, term_coef, term_expo, input ready);
	modport sink (input valid, command, poly_select, term_coef, term_expo, output ready);
endinterface

interface sptsa_rsp_if;
	logic                               valid;
	logic                               ready;
	sptsa_pkg::status_t                 status;
	logic signed [sptsa_pkg::SUM_W-1:0] sum_coef;
	logic [sptsa_pkg::EXPO_W-1:0]       sum_expo;
	logic                               last;

	modport source (output valid, status, sum_coef, sum_expo, last, input ready);
	modport sink (input valid, status, sum_coef, sum_expo, last, output ready);
endinterface

>>> rtl/sptsa_cell.sv
// Cell: one stored term, loaded from its right neighbor, the list head or a new term.
`timescale 1ns / 1ps
module sptsa_cell #(
	parameter int IW  = 5,
	parameter int IDX = 0
) (
	input  logic                                clk,
	input  sptsa_pkg::lop_t                     op,
	input  logic [IW-1:0]                       idx,
	input  logic [sptsa_pkg::COEF_W-1:0]        right_coef,
	input  logic [sptsa_pkg::EXPO_W-1:0]        right_expo,
	input  logic [sptsa_pkg::COEF_W-1:0]        head_coef,
	input  logic [sptsa_pkg::EXPO_W-1:0]        head_expo,
	input  logic [sptsa_pkg::COEF_W-1:0]        new_coef,
	input  logic [sptsa_pkg::EXPO_W-1:0]        new_expo,
	output logic [sptsa_pkg::COEF_W-1:0]        coef,
	output logic [sptsa_pkg::EXPO_W-1:0]        expo
);

	logic [sptsa_pkg::COEF_W-1:0] coef_q;
	logic [sptsa_pkg::EXPO_W-1:0] expo_q;
	logic                         mine;

	assign mine = (idx == IW'(IDX));

	always_ff @(posedge clk) begin
		case (op)
			sptsa_pkg::LOP_ROT: begin
				// the tail slot takes the old head, the rest advance
				coef_q <= mine ? head_coef : right_coef;
				expo_q <= mine ? head_expo : right_expo;
			end
			sptsa_pkg::LOP_POP: begin
				coef_q <= right_coef;
				expo_q <= right_expo;
			end
			sptsa_pkg::LOP_PUSH: begin
				if (mine) begin
					coef_q <= new_coef;
					expo_q <= new_expo;
				end
			end
			default: begin
			end
		endcase
	end

	assign coef = coef_q;
	assign expo = expo_q;

endmodule

>>> rtl/sptsa_list.sv
// List: a row of term cells for one polynomial plus its term count.
`timescale 1ns / 1ps
module sptsa_list #(
	parameter int N = sptsa_pkg::TERMS_PER_POLY
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sptsa_pkg::lop_t              op,
	input  logic [sptsa_pkg::COEF_W-1:0] new_coef,
	input  logic [sptsa_pkg::EXPO_W-1:0] new_expo,
	output logic [sptsa_pkg::COEF_W-1:0] head_coef,
	output logic [sptsa_pkg::EXPO_W-1:0] head_expo,
	output logic [$clog2(N+1)-1:0]       cnt
);

	localparam int IW = $clog2(N);
	localparam int CW = $clog2(N + 1);

	logic [CW-1:0]                cnt_q;
	logic [IW-1:0]                idx;
	logic [sptsa_pkg::COEF_W-1:0] coefs [N];
	logic [sptsa_pkg::EXPO_W-1:0] expos [N];

	// rotate writes the tail slot, push writes the slot past the tail
	assign idx = (op == sptsa_pkg::LOP_PUSH) ? IW'(cnt_q) : IW'(cnt_q - CW'(1));

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [sptsa_pkg::COEF_W-1:0] rc;
		logic [sptsa_pkg::EXPO_W-1:0] re;
		if (i == N - 1) begin : g_end
			assign rc = coefs[0];
			assign re = expos[0];
		end else begin : g_mid
			assign rc = coefs[i+1];
			assign re = expos[i+1];
		end
		sptsa_cell #(.IW(IW), .IDX(i)) u_cell (
			.clk       (clk),
			.op        (op),
			.idx       (idx),
			.right_coef(rc),
			.right_expo(re),
			.head_coef (coefs[0]),
			.head_expo (expos[0]),
			.new_coef  (new_coef),
			.new_expo  (new_expo),
			.coef      (coefs[i]),
			.expo      (expos[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (op)
				sptsa_pkg::LOP_POP:  cnt_q <= cnt_q - CW'(1);
				sptsa_pkg::LOP_PUSH: cnt_q <= cnt_q + CW'(1);
				default:             cnt_q <= cnt_q;
			endcase
		end
	end

	assign head_coef = coefs[0];
	assign head_expo = expos[0];
	assign cnt = cnt_q;

endmodule

>>> rtl/sparse_polynomial_term_store_adder.sv
// Top level: two term lists in cell rows, command sequencer and merge-add of the sum.
`timescale 1ns / 1ps
//
//  channel | dir | handshake   | word
//  --------+-----+-------------+-----------------------------------------------
//  req     | in  | valid/ready | command, poly_select, term_coef, term_expo
//  rsp     | out | valid/ready | status, sum_coef, sum_expo, last
//
//  Append pushes straight at the tail; delete, and insert ending at the tail, walk
//  the addressed list once (one row rotation per stored term); an insert placed
//  inside the list pushes mid-walk without rotating the row. Sum merges both rows,
//  one head compare per cycle while rsp is not stalled (matched exponents rotate
//  both rows at once); each result word is held back until the next one is known
//  so that last can be set on it. Reset clears both term counts; the cells hold no
//  reset. A stalled rsp holds the merge walk and the final word; req is taken
//  whenever the sequencer idles.
//
module sparse_polynomial_term_store_adder #(
	parameter int TERMS_PER_POLY = sptsa_pkg::TERMS_PER_POLY
) (
	input  logic         clk,
	input  logic         arst_n,
	sptsa_req_if.sink    req,
	sptsa_rsp_if.source  rsp
);

	localparam int CW = $clog2(TERMS_PER_POLY + 1);
	localparam int SUM_W = sptsa_pkg::SUM_W;

	sptsa_pkg::state_t state_q, state_d;

	// latched command word
	sptsa_pkg::cmd_t              cmd_q;
	logic                         sel_q;
	logic [sptsa_pkg::COEF_W-1:0] coef_q;
	logic [sptsa_pkg::EXPO_W-1:0] expo_q;

	logic               pend_q;   // insert or delete search still open
	sptsa_pkg::status_t status_q;
	logic [CW-1:0]      rem_q;    // original terms not yet rotated
	logic [CW-1:0]      ra_q, rb_q;

	// held sum term, released once the next one (or the end) is known
	logic                               hv_q;
	logic signed [sptsa_pkg::SUM_W-1:0] hc_q;
	logic [sptsa_pkg::EXPO_W-1:0]       he_q;

	// result register
	logic                               ov_q;
	sptsa_pkg::status_t                 os_q;
	logic signed [sptsa_pkg::SUM_W-1:0] oc_q;
	logic [sptsa_pkg::EXPO_W-1:0]       oe_q;
	logic                               ol_q;

	sptsa_pkg::lop_t              op0, op1;
	logic [sptsa_pkg::COEF_W-1:0] hc0, hc1;
	logic [sptsa_pkg::EXPO_W-1:0] he0, he1;
	logic [CW-1:0]                cnt0, cnt1;

	logic req_acc, out_free;

	assign req.ready = (state_q == sptsa_pkg::S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !ov_q || rsp.ready;

	sptsa_list #(.N(TERMS_PER_POLY)) u_list0 (
		.clk(clk), .arst_n(arst_n), .op(op0), .new_coef(coef_q), .new_expo(expo_q),
		.head_coef(hc0), .head_expo(he0), .cnt(cnt0)
	);

	sptsa_list #(.N(TERMS_PER_POLY)) u_list1 (
		.clk(clk), .arst_n(arst_n), .op(op1), .new_coef(coef_q), .new_expo(expo_q),
		.head_coef(hc1), .head_expo(he1), .cnt(cnt1)
	);

	// ---- single-list walk: decide what the addressed row does this cycle ----
	logic [CW-1:0]                sel_cnt;
	logic [sptsa_pkg::EXPO_W-1:0] sel_he;
	logic                         full, hit_eq, hit_lt;
	sptsa_pkg::lop_t              w_op;
	sptsa_pkg::status_t           w_status;
	logic                         w_resolve;

	assign sel_cnt = sel_q ? cnt1 : cnt0;
	assign sel_he  = sel_q ? he1 : he0;
	assign full    = (sel_cnt == CW'(TERMS_PER_POLY));
	assign hit_eq  = (sel_he == expo_q);
	assign hit_lt  = (sel_he < expo_q);

	always_comb begin
		w_op      = sptsa_pkg::LOP_ROT;
		w_status  = status_q;
		w_resolve = 1'b0;
		if (rem_q == '0) begin
			// walk over: an open search ends at the tail
			w_op      = sptsa_pkg::LOP_HOLD;
			w_resolve = pend_q;
			if (pend_q) begin
				if (cmd_q == sptsa_pkg::CMD_DELETE) begin
					w_status = sptsa_pkg::ST_NOTFOUND;
				end else if (full) begin
					w_status = sptsa_pkg::ST_FULL;
				end else begin
					w_op     = sptsa_pkg::LOP_PUSH;
					w_status = sptsa_pkg::ST_DONE;
				end
			end
		end else if (pend_q && cmd_q == sptsa_pkg::CMD_INSERT && hit_eq) begin
			w_status  = sptsa_pkg::ST_DUP;
			w_resolve = 1'b1;
		end else if (pend_q && cmd_q == sptsa_pkg::CMD_INSERT && hit_lt) begin
			// push the new term at the tail ahead of the current head
			w_resolve = 1'b1;
			if (full) begin
				w_status = sptsa_pkg::ST_FULL;
			end else begin
				w_op     = sptsa_pkg::LOP_PUSH;
				w_status = sptsa_pkg::ST_DONE;
			end
		end else if (pend_q && cmd_q == sptsa_pkg::CMD_DELETE && hit_eq) begin
			w_op      = sptsa_pkg::LOP_POP;
			w_status  = sptsa_pkg::ST_DONE;
			w_resolve = 1'b1;
		end
	end

	// ---- merge step of the sum ----
	logic                               a_ok, b_ok, s_end, s_match, s_take_a, s_tv;
	logic signed [sptsa_pkg::SUM_W-1:0] s_add, s_tc;
	logic [sptsa_pkg::EXPO_W-1:0]       s_te;
	sptsa_pkg::lop_t                    s_opa, s_opb;

	assign a_ok    = (ra_q != '0);
	assign b_ok    = (rb_q != '0);
	assign s_end   = !a_ok && !b_ok;
	assign s_match = a_ok && b_ok && (he0 == he1);
	assign s_take_a = !b_ok || (a_ok && (he0 > he1));
	assign s_add   = SUM_W'(signed'(hc0)) + SUM_W'(signed'(hc1));

	always_comb begin
		s_opa = sptsa_pkg::LOP_HOLD;
		s_opb = sptsa_pkg::LOP_HOLD;
		s_tv  = 1'b1;
		s_tc  = SUM_W'(signed'(hc1));
		s_te  = he1;
		if (s_end) begin
			s_tv = 1'b0;
		end else if (s_match) begin
			s_opa = sptsa_pkg::LOP_ROT;
			s_opb = sptsa_pkg::LOP_ROT;
			s_tc  = s_add;
			s_te  = he0;
			s_tv  = (s_add != '0);   // drop a cancelled pair
		end else if (s_take_a) begin
			s_opa = sptsa_pkg::LOP_ROT;
			s_tc  = SUM_W'(signed'(hc0));
			s_te  = he0;
		end else begin
			s_opb = sptsa_pkg::LOP_ROT;
		end
	end

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			sptsa_pkg::S_IDLE: begin
				if (req_acc) begin
					state_d = (req.command == sptsa_pkg::CMD_SUM) ? sptsa_pkg::S_SUM
					                                              : sptsa_pkg::S_WALK;
				end
			end
			sptsa_pkg::S_WALK: begin
				if (rem_q == '0) state_d = sptsa_pkg::S_FINISH;
			end
			sptsa_pkg::S_FINISH: begin
				if (out_free) state_d = sptsa_pkg::S_IDLE;
			end
			sptsa_pkg::S_SUM: begin
				if (out_free && s_end) state_d = sptsa_pkg::S_IDLE;
			end
			default: state_d = sptsa_pkg::S_IDLE;
		endcase
	end

	// ---- outputs of the sequencer ----
	logic                               o_load;
	sptsa_pkg::status_t                 o_status;
	logic signed [sptsa_pkg::SUM_W-1:0] o_coef;
	logic [sptsa_pkg::EXPO_W-1:0]       o_expo;
	logic                               o_last;
	logic                               s_step, w_step;

	always_comb begin
		op0      = sptsa_pkg::LOP_HOLD;
		op1      = sptsa_pkg::LOP_HOLD;
		o_load   = 1'b0;
		o_status = status_q;
		o_coef   = '0;
		o_expo   = '0;
		o_last   = 1'b1;
		s_step   = 1'b0;
		w_step   = 1'b0;
		case (state_q)
			sptsa_pkg::S_WALK: begin
				w_step = 1'b1;
				if (sel_q) op1 = w_op;
				else       op0 = w_op;
			end
			sptsa_pkg::S_FINISH: begin
				o_load = out_free;
			end
			sptsa_pkg::S_SUM: begin
				if (out_free) begin
					s_step = 1'b1;
					op0    = s_opa;
					op1    = s_opb;
					if (s_end) begin
						o_load   = 1'b1;
						o_status = hv_q ? sptsa_pkg::ST_TERM : sptsa_pkg::ST_EMPTY;
						o_coef   = hv_q ? hc_q : '0;
						o_expo   = hv_q ? he_q : '0;
					end else if (s_tv && hv_q) begin
						o_load   = 1'b1;
						o_status = sptsa_pkg::ST_TERM;
						o_coef   = hc_q;
						o_expo   = he_q;
						o_last   = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// ---- registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sptsa_pkg::S_IDLE;
			pend_q  <= 1'b0;
			rem_q   <= '0;
			ra_q    <= '0;
			rb_q    <= '0;
			hv_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_acc) begin
				pend_q <= 1'b1;
				hv_q   <= 1'b0;
				ra_q   <= cnt0;
				rb_q   <= cnt1;
				// append skips the search and goes straight to the tail
				rem_q  <= (req.command == sptsa_pkg::CMD_APPEND) ? '0
				        : (req.poly_select ? cnt1 : cnt0);
			end
			if (w_step) begin
				if (w_resolve) pend_q <= 1'b0;
				if (w_op == sptsa_pkg::LOP_ROT || w_op == sptsa_pkg::LOP_POP) begin
					rem_q <= rem_q - CW'(1);
				end
			end
			if (s_step) begin
				if (s_opa == sptsa_pkg::LOP_ROT) ra_q <= ra_q - CW'(1);
				if (s_opb == sptsa_pkg::LOP_ROT) rb_q <= rb_q - CW'(1);
				if (s_tv) hv_q <= 1'b1;
			end
			if (o_load)           ov_q <= 1'b1;
			else if (rsp.ready)   ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q  <= req.command;
			sel_q  <= req.poly_select;
			coef_q <= req.term_coef;
			expo_q <= req.term_expo;
		end
		if (w_step) status_q <= w_status;
		if (s_step && s_tv) begin
			hc_q <= s_tc;
			he_q <= s_te;
		end
		if (o_load) begin
			os_q <= o_status;
			oc_q <= o_coef;
			oe_q <= o_expo;
			ol_q <= o_last;
		end
	end

	assign rsp.valid    = ov_q;
	assign rsp.status   = os_q;
	assign rsp.sum_coef = oc_q;
	assign rsp.sum_expo = oe_q;
	assign rsp.last     = ol_q;

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt0 <= CW'(TERMS_PER_POLY) && cnt1 <= CW'(TERMS_PER_POLY))
		else $error("term count beyond list size");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> state_q != sptsa_pkg::S_IDLE)
		else $error("sequencer stayed idle after taking a command");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && os_q == sptsa_pkg::ST_EMPTY |-> ol_q)
		else $error("empty sum word without last");
`endif

endmodule
